// ===== src/tssg_pkg.sv =====
// shared types and codes for the triangle scanline span generator
// no dependencies; used by every module of the block except tssg_div
`default_nettype none

package tssg_pkg;

    localparam int ROW_W = 6;
    localparam int COL_W = 8;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
    } vtx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DOWN,
        ST_UP
    } state_t;

    typedef enum logic [2:0] {
        OP_SPLIT,
        OP_SD1,
        OP_SD2,
        OP_SU1,
        OP_SU2
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_capture;
        div_op_t op;
        logic    step_down;
        logic    step_up;
        logic    emit;
        logic    phase_up;
    } cmd_t;

    typedef struct packed {
        logic flat_row;
        logic flat_bottom;
        logic flat_top;
        logic div_done;
        logic down_end;
        logic up_end;
        logic down_ok;
        logic up_ok;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== src/tssg_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// sign and floor correction applied to the final quotient; uses no package
`default_nettype none

module tssg_div #(
    parameter int NW = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [NW-1:0]        num,
    input  wire logic [5:0]           den,
    input  wire logic                 neg,
    input  wire logic                 floor_mode,
    output logic                      done,
    output logic signed [NW:0]        quot
);

    localparam int CW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] q_reg, q_next;
    logic [5:0]    rem_reg, rem_next;
    logic [5:0]    den_reg, den_next;
    logic          neg_reg, neg_next;
    logic          floor_reg, floor_next;

    logic [6:0]    rem_sh;
    logic          qbit;
    logic [NW:0]   mag;

    always_comb begin
        rem_sh     = {rem_reg, num_reg[NW-1]};
        qbit       = (rem_sh >= {1'b0, den_reg});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        floor_next = floor_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CW'(NW - 1);
            num_next   = num;
            q_next     = '0;
            rem_next   = '0;
            den_next   = den;
            neg_next   = neg;
            floor_next = floor_mode;
        end else if (busy_reg) begin
            rem_next = qbit ? 6'(rem_sh - {1'b0, den_reg}) : rem_sh[5:0];
            q_next   = {q_reg[NW-2:0], qbit};
            num_next = {num_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg   <= cnt_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        floor_reg <= floor_next;
    end

    // truncating quotient, or floor when asked and the dividend is negative
    always_comb begin
        mag = {1'b0, q_reg};
        if (neg_reg) begin
            quot = $signed(-mag);
            if (floor_reg && (rem_reg != '0)) begin
                quot = $signed(-mag - 1'b1);
            end
        end else begin
            quot = $signed(mag);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/tssg_datapath.sv =====
// vertex sort, slope setup, edge stepping and output register
// depends on tssg_pkg and tssg_div
`default_nettype none

module tssg_datapath #(
    parameter int FRAME_ROWS = 64,
    parameter int FRAME_COLS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tssg_pkg::vtx_t       vin_a,
    input  wire tssg_pkg::vtx_t       vin_b,
    input  wire tssg_pkg::vtx_t       vin_c,
    input  wire tssg_pkg::cmd_t       cmd,
    output tssg_pkg::status_t         status,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic [5:0]                m_row,
    output logic [7:0]                m_left,
    output logic [7:0]                m_right,
    output logic                      m_last
);

    localparam int NW = 8 + FRAC_BITS;
    localparam int PW = NW + 2;
    localparam int COL_MAX = FRAME_COLS - 1;
    localparam logic [6:0] ROWS7 = 7'(FRAME_ROWS);
    localparam logic [6:0] ROWLAST7 = 7'(FRAME_ROWS - 1);

    function automatic logic before_f(tssg_pkg::vtx_t p, tssg_pkg::vtx_t q);
        return (p.y == q.y) ? (p.x < q.x) : (p.y < q.y);
    endfunction

    function automatic logic [7:0] col_of(logic signed [PW-1:0] pos);
        logic [8:0] c;
        c = pos[FRAC_BITS+8:FRAC_BITS];
        if (pos[PW-1]) begin
            return 8'd0;
        end else if (32'(c) > COL_MAX) begin
            return 8'(COL_MAX);
        end
        return c[7:0];
    endfunction

    function automatic logic signed [PW-1:0] pos_of(logic [7:0] x);
        return $signed({2'b00, x, {FRAC_BITS{1'b0}}});
    endfunction

    function automatic logic signed [PW-1:0] sext(logic signed [NW:0] s);
        return $signed({s[NW], s});
    endfunction

    function automatic logic signed [8:0] diff(logic [7:0] p, logic [7:0] q);
        return $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    // sorted vertices: top, middle, bottom
    tssg_pkg::vtx_t t_reg, m_reg, b_reg;
    logic [7:0]     sx_reg;
    logic signed [NW:0] sd1_reg, sd2_reg, su1_reg, su2_reg;
    logic signed [PW-1:0] pd1_reg, pd2_reg, pu1_reg, pu2_reg;
    logic [5:0]     dn_row_reg, up_row_reg;

    logic           mv_reg;
    logic [5:0]     mrow_reg;
    logic [7:0]     mleft_reg, mright_reg;
    logic           mlast_reg;

    tssg_pkg::vtx_t s0, s1, s2, tmp;
    logic           flat_row, flat_bottom, flat_top, has_up, up_any;
    logic [5:0]     up_stop;

    logic signed [8:0] dx;
    logic [7:0]     mag8;
    logic [5:0]     dyv;
    logic           split_op;
    logic [13:0]    prod;
    logic [NW-1:0]  div_num;
    logic           div_done;
    logic signed [NW:0] quot;

    logic [7:0]     ca, cb, lo, hi;
    logic [5:0]     cur_row;
    logic           cur_last;

    // three compare-and-swap steps
    always_comb begin
        s0  = vin_a;
        s1  = vin_b;
        s2  = vin_c;
        tmp = vin_a;
        if (before_f(s1, s0)) begin
            tmp = s0; s0 = s1; s1 = tmp;
        end
        if (before_f(s2, s1)) begin
            tmp = s1; s1 = s2; s2 = tmp;
        end
        if (before_f(s1, s0)) begin
            tmp = s0; s0 = s1; s1 = tmp;
        end
    end

    always_comb begin
        flat_row    = (t_reg.y == b_reg.y);
        flat_bottom = !flat_row && (m_reg.y == b_reg.y);
        flat_top    = !flat_row && (t_reg.y == m_reg.y);
        has_up      = !flat_row && !flat_bottom;
        up_stop     = flat_top ? t_reg.y : 6'(m_reg.y + 1'b1);
        up_any      = has_up && ({1'b0, up_stop} < ROWS7);
    end

    // divider operand selection
    always_comb begin
        split_op = 1'b0;
        dx       = '0;
        dyv      = 6'd1;
        unique case (cmd.op)
            tssg_pkg::OP_SPLIT: begin
                split_op = 1'b1;
                dx       = diff(b_reg.x, t_reg.x);
                dyv      = b_reg.y - t_reg.y;
            end
            tssg_pkg::OP_SD1: begin
                dx  = diff(m_reg.x, t_reg.x);
                dyv = m_reg.y - t_reg.y;
            end
            tssg_pkg::OP_SD2: begin
                dx  = diff(sx_reg, t_reg.x);
                dyv = m_reg.y - t_reg.y;
            end
            tssg_pkg::OP_SU1: begin
                dx  = diff(b_reg.x, flat_top ? t_reg.x : m_reg.x);
                dyv = b_reg.y - m_reg.y;
            end
            tssg_pkg::OP_SU2: begin
                dx  = diff(b_reg.x, flat_top ? m_reg.x : sx_reg);
                dyv = b_reg.y - m_reg.y;
            end
            default: begin
                dx  = '0;
                dyv = 6'd1;
            end
        endcase
        mag8    = dx[8] ? 8'(-dx) : dx[7:0];
        prod    = mag8 * (m_reg.y - t_reg.y);
        div_num = split_op ? NW'(prod) : {mag8, {FRAC_BITS{1'b0}}};
    end

    tssg_div #(
        .NW(NW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.div_start),
        .num        (div_num),
        .den        (dyv),
        .neg        (dx[8]),
        .floor_mode (split_op),
        .done       (div_done),
        .quot       (quot)
    );

    // current span candidate
    always_comb begin
        if (cmd.phase_up) begin
            ca       = col_of(pu1_reg);
            cb       = col_of(pu2_reg);
            cur_row  = up_row_reg;
            cur_last = (up_row_reg == up_stop);
        end else begin
            ca       = col_of(pd1_reg);
            cb       = col_of(pd2_reg);
            cur_row  = dn_row_reg;
            cur_last = status.down_end && !up_any;
        end
        lo = (ca < cb) ? ca : cb;
        hi = (ca < cb) ? cb : ca;
    end

    always_comb begin
        status.flat_row    = flat_row;
        status.flat_bottom = flat_bottom;
        status.flat_top    = flat_top;
        status.div_done    = div_done;
        status.down_ok     = ({1'b0, dn_row_reg} < ROWS7);
        status.down_end    = (dn_row_reg == m_reg.y) || ({1'b0, dn_row_reg} >= ROWLAST7);
        status.up_ok       = ({1'b0, up_row_reg} < ROWS7);
        status.up_end      = (up_row_reg == up_stop);
        status.out_free    = !mv_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg      <= s0;
            m_reg      <= s1;
            b_reg      <= s2;
            sx_reg     <= s2.x;
            sd1_reg    <= '0;
            sd2_reg    <= '0;
            su1_reg    <= '0;
            su2_reg    <= '0;
            pd1_reg    <= pos_of(s0.x);
            pd2_reg    <= (s0.y == s2.y) ? pos_of(s2.x) : pos_of(s0.x);
            pu1_reg    <= pos_of(s2.x);
            pu2_reg    <= pos_of(s2.x);
            dn_row_reg <= s0.y;
            up_row_reg <= s2.y;
        end else begin
            if (cmd.div_capture) begin
                case (cmd.op)
                    tssg_pkg::OP_SPLIT: sx_reg  <= t_reg.x + quot[7:0];
                    tssg_pkg::OP_SD1:   sd1_reg <= quot;
                    tssg_pkg::OP_SD2:   sd2_reg <= quot;
                    tssg_pkg::OP_SU1:   su1_reg <= quot;
                    tssg_pkg::OP_SU2:   su2_reg <= quot;
                    default:            sx_reg  <= sx_reg;
                endcase
            end
            if (cmd.step_down) begin
                pd1_reg    <= pd1_reg + sext(sd1_reg);
                pd2_reg    <= pd2_reg + sext(sd2_reg);
                dn_row_reg <= dn_row_reg + 1'b1;
            end
            if (cmd.step_up) begin
                pu1_reg    <= pu1_reg - sext(su1_reg);
                pu2_reg    <= pu2_reg - sext(su2_reg);
                up_row_reg <= up_row_reg - 1'b1;
            end
        end
        if (cmd.emit) begin
            mrow_reg   <= cur_row;
            mleft_reg  <= lo;
            mright_reg <= hi;
            mlast_reg  <= cur_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.emit) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    assign m_valid = mv_reg;
    assign m_row   = mrow_reg;
    assign m_left  = mleft_reg;
    assign m_right = mright_reg;
    assign m_last  = mlast_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!mv_reg || m_ready))
        else $error("span written over an untaken span");

    a_ordered_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (mleft_reg <= mright_reg))
        else $error("span ends out of order");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> ({1'b0, mrow_reg} < ROWS7))
        else $error("span row outside the frame");

    a_no_step_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_capture |-> !(cmd.step_down || cmd.step_up || cmd.emit))
        else $error("edge stepping during slope setup");

endmodule

`default_nettype wire

// ===== src/tssg_ctrl.sv =====
// sequencer: accept, slope divisions, then one span per cycle per phase while the output is free
// depends on tssg_pkg
`default_nettype none

module tssg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tssg_pkg::status_t  status,
    output tssg_pkg::cmd_t          cmd
);

    tssg_pkg::state_t  state_reg, state_next;
    tssg_pkg::div_op_t op_reg, op_next;
    logic              has_up;

    assign has_up = !status.flat_row && !status.flat_bottom;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            tssg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tssg_pkg::ST_SETUP;
                end
            end
            tssg_pkg::ST_SETUP: begin
                if (status.flat_row) begin
                    state_next = tssg_pkg::ST_DOWN;
                end else begin
                    state_next = tssg_pkg::ST_DIV_GO;
                    if (status.flat_bottom) begin
                        op_next = tssg_pkg::OP_SD1;
                    end else if (status.flat_top) begin
                        op_next = tssg_pkg::OP_SU1;
                    end else begin
                        op_next = tssg_pkg::OP_SPLIT;
                    end
                end
            end
            tssg_pkg::ST_DIV_GO: begin
                state_next = tssg_pkg::ST_DIV_WAIT;
            end
            tssg_pkg::ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = tssg_pkg::ST_DIV_GO;
                    unique case (op_reg)
                        tssg_pkg::OP_SPLIT: op_next = tssg_pkg::OP_SD1;
                        tssg_pkg::OP_SD1:   op_next = tssg_pkg::OP_SD2;
                        tssg_pkg::OP_SD2: begin
                            if (status.flat_bottom) begin
                                state_next = tssg_pkg::ST_DOWN;
                            end else begin
                                op_next = tssg_pkg::OP_SU1;
                            end
                        end
                        tssg_pkg::OP_SU1:   op_next = tssg_pkg::OP_SU2;
                        tssg_pkg::OP_SU2: begin
                            state_next = status.flat_top ? tssg_pkg::ST_UP
                                                         : tssg_pkg::ST_DOWN;
                        end
                        default: state_next = tssg_pkg::ST_IDLE;
                    endcase
                end
            end
            tssg_pkg::ST_DOWN: begin
                if (status.out_free && status.down_end) begin
                    state_next = has_up ? tssg_pkg::ST_UP : tssg_pkg::ST_IDLE;
                end
            end
            tssg_pkg::ST_UP: begin
                if (status.out_free && status.up_end) begin
                    state_next = tssg_pkg::ST_IDLE;
                end
            end
            default: state_next = tssg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        cmd.op  = op_reg;
        unique case (state_reg)
            tssg_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tssg_pkg::ST_DIV_GO: begin
                cmd.div_start = 1'b1;
            end
            tssg_pkg::ST_DIV_WAIT: begin
                cmd.div_capture = status.div_done;
            end
            tssg_pkg::ST_DOWN: begin
                cmd.step_down = status.out_free;
                cmd.emit      = status.out_free && status.down_ok;
            end
            tssg_pkg::ST_UP: begin
                cmd.phase_up = 1'b1;
                cmd.step_up  = status.out_free;
                cmd.emit     = status.out_free && status.up_ok;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tssg_pkg::ST_IDLE;
            op_reg    <= tssg_pkg::OP_SPLIT;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/triangle_scanline_span_generator.sv =====
// top level of the triangle scanline span generator
// depends on tssg_pkg, tssg_ctrl, tssg_datapath (and tssg_div below it)
`default_nettype none

// One triangle per input transaction, one span per covered scanline on the
// output. Vertices are sorted top to bottom (ties by column). A flat-bottom
// triangle gives rows top to bottom; a flat-top one gives rows from the
// bottom vertex up to the top row; any other triangle is split at the middle
// row: rows top..middle ascending, then bottom..middle+1 descending. A
// triangle lying in one row gives a single span. Rows at or beyond
// FRAME_ROWS are dropped, columns are clamped to FRAME_COLS-1, and tlast
// marks the final span that is sent. Edge slopes come from one shared
// divider that produces one quotient bit per cycle; a general triangle
// needs five divisions (split column and four slopes), a flat-top or
// flat-bottom one two, a single-row one none. After that setup the edge
// stepper sends one span per cycle while the output is taken. A new
// triangle is accepted as soon as the last span sits in the output
// register.

module triangle_scanline_span_generator #(
    parameter int FRAME_ROWS = 64,
    parameter int FRAME_COLS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input triangle
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vertex_a_x[7:0] vertex_a_y[13:8] vertex_b_x[21:14] vertex_b_y[27:22]
    // vertex_c_x[35:28] vertex_c_y[41:36], zero pad to 48
    input  wire logic [47:0] s_tdata,
    // output spans
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // span_row[5:0] span_left[13:6] span_right[21:14], zero pad to 24
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    tssg_pkg::cmd_t    cmd;
    tssg_pkg::status_t status;
    tssg_pkg::vtx_t    vin_a, vin_b, vin_c;

    logic [5:0] span_row;
    logic [7:0] span_left, span_right;

    // unpack the vertex fields
    assign vin_a = '{x: s_tdata[7:0],   y: s_tdata[13:8]};
    assign vin_b = '{x: s_tdata[21:14], y: s_tdata[27:22]};
    assign vin_c = '{x: s_tdata[35:28], y: s_tdata[41:36]};

    // sequencer: accepts a triangle only when idle
    tssg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // sorting, slopes, edge stepping, output register
    tssg_datapath #(
        .FRAME_ROWS (FRAME_ROWS),
        .FRAME_COLS (FRAME_COLS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .vin_a   (vin_a),
        .vin_b   (vin_b),
        .vin_c   (vin_c),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_row   (span_row),
        .m_left  (span_left),
        .m_right (span_right),
        .m_last  (m_tlast)
    );

    // pack the span transaction
    assign m_tdata = {2'b00, span_right, span_left, span_row};

endmodule

`default_nettype wire

// ===== bench/tb_triangle_scanline_span_generator.sv =====
// self-checking bench for the triangle scanline span generator
// depends on triangle_scanline_span_generator
`timescale 1ns / 100ps
`default_nettype none

module tb_triangle_scanline_span_generator;

    localparam int FRAME_ROWS = 64;
    localparam int FRAME_COLS = 256;
    localparam int FRAC_BITS  = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [5:0] row;
        logic [7:0] left;
        logic [7:0] right;
        logic       last;
    } span_t;

    typedef struct {
        longint x;
        longint y;
    } pt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    logic [47:0] tri_queue[$];
    span_t       span_queue[$];
    span_t       tri_spans[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          drain_hold = 1'b0;
    int          hold_len = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    triangle_scanline_span_generator #(
        .FRAME_ROWS(FRAME_ROWS),
        .FRAME_COLS(FRAME_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // edge column of a fixed-point position, negative positions give 0
    function automatic longint edge_column(longint pos);
        return (pos < 0) ? 0 : (pos >>> FRAC_BITS);
    endfunction

    function automatic longint edge_slope(longint dx, longint dy);
        return (dy <= 0) ? 0 : (dx * (longint'(1) << FRAC_BITS)) / dy;
    endfunction

    task automatic add_span(longint row, longint c1, longint c2);
        longint lo;
        longint hi;
        span_t  s;
        lo = (c1 < c2) ? c1 : c2;
        hi = (c1 < c2) ? c2 : c1;
        if (row < 0 || row >= FRAME_ROWS || tri_spans.size() >= 64) return;
        if (lo < 0) lo = 0;
        if (hi < 0) hi = 0;
        if (lo > FRAME_COLS - 1) lo = FRAME_COLS - 1;
        if (hi > FRAME_COLS - 1) hi = FRAME_COLS - 1;
        s.row = row[5:0];
        s.left = lo[7:0];
        s.right = hi[7:0];
        s.last = 1'b0;
        tri_spans.push_back(s);
    endtask

    // rows from the apex down to the flat edge p-q
    task automatic walk_down(pt_t apex, pt_t p, pt_t q);
        longint s1;
        longint s2;
        longint c1;
        longint c2;
        s1 = edge_slope(p.x - apex.x, p.y - apex.y);
        s2 = edge_slope(q.x - apex.x, q.y - apex.y);
        c1 = apex.x * (longint'(1) << FRAC_BITS);
        c2 = c1;
        for (longint r = apex.y; r <= p.y; r++) begin
            add_span(r, edge_column(c1), edge_column(c2));
            c1 += s1;
            c2 += s2;
        end
    endtask

    // rows from the bottom apex up to stop_row
    task automatic walk_up(pt_t p, pt_t q, pt_t apex, longint stop_row);
        longint s1;
        longint s2;
        longint c1;
        longint c2;
        s1 = edge_slope(apex.x - p.x, apex.y - p.y);
        s2 = edge_slope(apex.x - q.x, apex.y - q.y);
        c1 = apex.x * (longint'(1) << FRAC_BITS);
        c2 = c1;
        for (longint r = apex.y; r >= stop_row; r--) begin
            add_span(r, edge_column(c1), edge_column(c2));
            c1 -= s1;
            c2 -= s2;
        end
    endtask

    // spans of one triangle, appended to the expected span queue
    task automatic predict_spans(logic [47:0] d);
        pt_t    v[3];
        pt_t    tmp;
        pt_t    sp;
        longint num;
        longint den;
        longint q;
        for (int i = 0; i < 3; i++) begin
            v[i].x = d[14*i +: 8];
            v[i].y = d[14*i+8 +: 6];
        end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2 - i; j++)
                if ((v[j+1].y == v[j].y) ? (v[j+1].x < v[j].x) : (v[j+1].y < v[j].y)) begin
                    tmp = v[j];
                    v[j] = v[j+1];
                    v[j+1] = tmp;
                end
        tri_spans.delete();
        if (v[0].y == v[2].y) begin
            add_span(v[0].y, v[0].x, v[2].x);
        end else if (v[1].y == v[2].y) begin
            walk_down(v[0], v[1], v[2]);
        end else if (v[0].y == v[1].y) begin
            walk_up(v[0], v[1], v[2], v[0].y);
        end else begin
            num = (v[1].y - v[0].y) * (v[2].x - v[0].x);
            den = v[2].y - v[0].y;
            q = num / den;
            if ((num % den != 0) && (num < 0)) q -= 1;
            sp.x = v[0].x + q;
            sp.y = v[1].y;
            walk_down(v[0], v[1], sp);
            walk_up(v[1], sp, v[2], v[1].y + 1);
        end
        if (tri_spans.size() > 0) tri_spans[tri_spans.size()-1].last = 1'b1;
        foreach (tri_spans[i]) span_queue.push_back(tri_spans[i]);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [47:0] pack_tri(int ax, int ay, int bx, int by, int cx, int cy);
        return {cy[5:0], cx[7:0], by[5:0], bx[7:0], ay[5:0], ax[7:0]};
    endfunction

    // small row spans keep the run short; one in sixteen triangles is fully random
    function automatic logic [47:0] random_tri();
        int base;
        int h;
        if ($urandom_range(0, 15) == 0) return 48'($urandom) | (48'($urandom) << 32);
        h = $urandom_range(0, 12);
        base = $urandom_range(0, 63);
        return pack_tri($urandom_range(0, 255), (base + $urandom_range(0, h)) % 64,
                        $urandom_range(0, 255), (base + $urandom_range(0, h)) % 64,
                        $urandom_range(0, 255), (base + $urandom_range(0, h)) % 64);
    endfunction

    // driver: bursts and gaps, predicts each accepted triangle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_spans(s_tdata);
            if (!(s_tvalid && !s_tready)) begin
                if (drain_hold || tri_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tri_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_len > 0) begin
                hold_len <= hold_len - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0) || (($time / 400) % 3 == 0);
            end
        end
    end

    // monitor: compare every span transaction with the oldest expectation
    always @(posedge aclk) begin
        span_t exp_span;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout");
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (span_queue.size() == 0) begin
                    report_mismatch("span with none expected");
                end else begin
                    exp_span = span_queue.pop_front();
                    if (m_tdata[5:0] !== exp_span.row)
                        report_mismatch($sformatf("row %0d exp %0d", m_tdata[5:0], exp_span.row));
                    if (m_tdata[13:6] !== exp_span.left)
                        report_mismatch($sformatf("left %0d exp %0d", m_tdata[13:6], exp_span.left));
                    if (m_tdata[21:14] !== exp_span.right)
                        report_mismatch($sformatf("right %0d exp %0d", m_tdata[21:14],
                                                  exp_span.right));
                    if (m_tlast !== exp_span.last)
                        report_mismatch($sformatf("last %0b exp %0b", m_tlast, exp_span.last));
                end
            end
        end
    end

    initial begin
        // directed: one-row, flat bottom, flat top, general, extremes, off-left slopes
        tri_queue.push_back(pack_tri(10, 5, 200, 5, 100, 5));
        tri_queue.push_back(pack_tri(0, 0, 0, 0, 0, 0));
        tri_queue.push_back(pack_tri(255, 63, 255, 63, 255, 63));
        tri_queue.push_back(pack_tri(50, 2, 10, 12, 90, 12));
        tri_queue.push_back(pack_tri(10, 20, 90, 20, 50, 30));
        tri_queue.push_back(pack_tri(128, 0, 0, 63, 255, 63));
        tri_queue.push_back(pack_tri(0, 0, 255, 0, 128, 63));
        tri_queue.push_back(pack_tri(100, 10, 20, 15, 200, 25));
        tri_queue.push_back(pack_tri(100, 10, 220, 15, 5, 25));
        tri_queue.push_back(pack_tri(255, 0, 0, 32, 255, 63));
        tri_queue.push_back(pack_tri(0, 0, 255, 31, 0, 63));
        tri_queue.push_back(pack_tri(30, 40, 30, 41, 30, 42));
        tri_queue.push_back(pack_tri(7, 3, 7, 3, 200, 9));
        tri_queue.push_back(pack_tri(200, 9, 7, 3, 7, 3));
        tri_queue.push_back(pack_tri(1, 1, 254, 2, 3, 62));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // first the directed set with the receiver holding off for a while
        hold_len <= 400;
        wait (tri_queue.size() == 0);
        for (int i = 0; i < 320; i++) begin
            tri_queue.push_back(random_tri());
            if (i == 160) begin
                // pause the sender until every expected span has arrived
                wait (tri_queue.size() == 0);
                drain_hold = 1'b1;
                wait (!s_tvalid && span_queue.size() == 0);
                drain_hold = 1'b0;
            end
        end
        wait (tri_queue.size() == 0 && !s_tvalid && span_queue.size() == 0);
        repeat (400) @(posedge aclk);
        if (error_count == 0 && span_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/tssg_pkg.sv
src/tssg_div.sv
src/tssg_datapath.sv
src/tssg_ctrl.sv
src/triangle_scanline_span_generator.sv
bench/tb_triangle_scanline_span_generator.sv
